// ===== design/gmf3_pkg.sv =====
// ----------------------------------------------------------------------------
// gmf3_pkg
// Shared constants, controller/datapath interface types and a helper function
// for the 3x3 geometric mean filter.
// ----------------------------------------------------------------------------
package gmf3_pkg;

    localparam int DEF_MAX_WIDTH = 2048;
    localparam int DEF_FRAC_BITS = 8;

    localparam int CFG_W      = 12;
    localparam int PIX_W      = 8;
    localparam int OUT_W      = 16;
    localparam int PROD_W     = 9 * PIX_W;
    localparam int LIMB_W     = 32;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd1920;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd1281;
    localparam logic [CFG_W-1:0] DIM_MIN      = 12'd3;

    // Configuration register indexes.
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // Input function codes.
    localparam logic FUNC_PIXEL = 1'b0;
    localparam logic FUNC_DRAIN = 1'b1;

    // Kind of result an item produces.
    typedef logic [1:0] kind_t;
    localparam kind_t RES_NONE = 2'd0;
    localparam kind_t RES_PASS = 2'd1;
    localparam kind_t RES_ROOT = 2'd2;

    typedef struct packed {
        logic accept;     // transaction taken, launch line store reads
        logic step;       // window/counter update with read data
        logic prod_step;  // one multiply of the window product
        logic cand_load;  // load next root candidate
        logic mul_step;   // one limb of candidate power multiply
        logic cmp_step;   // compare candidate power against target
        logic load_out;   // move staged result into output register
    } cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  prod_last;
        logic  mul_last;
        logic  bit_last;
    } status_t;

    function automatic logic [OUT_W-1:0] sat16(input logic [31:0] v);
        logic [OUT_W-1:0] r;
        if (v > 32'h0000_FFFF)
        begin
            r = '1;
        end
        else
        begin
            r = v[OUT_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== design/gmf3_ram.sv =====
// ----------------------------------------------------------------------------
// gmf3_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module gmf3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/gmf3_ctrl.sv =====
// ----------------------------------------------------------------------------
// gmf3_ctrl
// Controller state machine: sequences line store access, the window product,
// the bitwise ninth-root search and the output register handshake.
// ----------------------------------------------------------------------------
module gmf3_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pix_valid,
    output logic              pix_stall,
    output logic              res_valid,
    input  logic              res_stall,
    input  gmf3_pkg::status_t status,
    output gmf3_pkg::cmd_t    cmd
);
    import gmf3_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_READ = 3'd1;
    localparam logic [2:0] ST_PROD = 3'd2;
    localparam logic [2:0] ST_CAND = 3'd3;
    localparam logic [2:0] ST_MUL  = 3'd4;
    localparam logic [2:0] ST_CMP  = 3'd5;
    localparam logic [2:0] ST_EMIT = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign pix_stall = (state_reg != ST_IDLE);
    assign res_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || !res_stall;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg && res_stall;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pix_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.step = 1'b1;
                case (status.kind)
                    RES_PASS: state_next = ST_EMIT;
                    RES_ROOT: state_next = ST_PROD;
                    default:  state_next = ST_IDLE;
                endcase
            end
            ST_PROD:
            begin
                cmd.prod_step = 1'b1;
                if (status.prod_last)
                begin
                    state_next = ST_CAND;
                end
            end
            ST_CAND:
            begin
                cmd.cand_load = 1'b1;
                state_next    = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul_step = 1'b1;
                if (status.mul_last)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                cmd.cmp_step = 1'b1;
                state_next   = status.bit_last ? ST_EMIT : ST_CAND;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_accept_to_read: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_valid && !pix_stall) |=> (state_reg == ST_READ))
        else $error("accepted transaction did not move to line store read");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || !res_stall))
        else $error("output register overwritten while result pending");

    a_root_done_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CMP && status.bit_last) |=> (state_reg == ST_EMIT))
        else $error("root search finished without emitting");
`endif

endmodule

// ===== design/gmf3_datapath.sv =====
// ----------------------------------------------------------------------------
// gmf3_datapath
// Line stores, 3x3 window, frame counters, product and ninth-root engine,
// result staging and output register.
// ----------------------------------------------------------------------------
module gmf3_datapath #(
    parameter int MAX_WIDTH = gmf3_pkg::DEF_MAX_WIDTH,
    parameter int FRAC_BITS = gmf3_pkg::DEF_FRAC_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           func,
    input  logic [gmf3_pkg::PIX_W-1:0]     pixel,
    input  logic                           cfg_we,
    input  logic                           cfg_index,
    input  logic [gmf3_pkg::CFG_W-1:0]     cfg_data,
    input  gmf3_pkg::cmd_t                 cmd,
    output gmf3_pkg::status_t              status,
    output logic [gmf3_pkg::OUT_W-1:0]     mean_value,
    output logic                           on_border,
    output logic                           frame_end
);
    import gmf3_pkg::*;

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = PIX_W + FRAC_BITS;
    localparam int BW    = $clog2(RW);
    localparam int AW    = 9 * RW;
    localparam int NL    = (AW + LIMB_W - 1) / LIMB_W;
    localparam int LW    = $clog2(NL);
    localparam int AWP   = NL * LIMB_W;
    localparam int SHIFT = 9 * FRAC_BITS;
    localparam int PW    = LIMB_W + RW;

    // Configuration and counters.
    logic [CFG_W-1:0] width_reg, height_reg;
    logic [CW-1:0]    col_reg;
    logic [CFG_W-1:0] row_reg, drain_reg;
    logic [CFG_W-1:0] eff_w, eff_h;

    always_comb
    begin
        eff_w = width_reg;
        if (width_reg < DIM_MIN)
        begin
            eff_w = DIM_MIN;
        end
        else if ({2'b00, width_reg} > 14'(MAX_WIDTH))
        begin
            eff_w = CFG_W'(MAX_WIDTH);
        end
        eff_h = (height_reg < DIM_MIN) ? DIM_MIN : height_reg;
    end

    logic          frame_done;
    logic [CW-1:0] xx;
    logic [13:0]   x_inc;
    assign frame_done = (row_reg >= eff_h);
    assign xx    = ({{(14-CW){1'b0}}, col_reg} >= {2'b00, eff_w}) ? '0 : col_reg;
    assign x_inc = {{(14-CW){1'b0}}, xx} + 14'd1;

    // Latched input.
    logic             func_reg;
    logic [PIX_W-1:0] pixel_reg;

    // Line stores.
    logic [CW-1:0]    raddr;
    logic [PIX_W-1:0] up_rdata, mid_rdata;
    logic             ram_we;
    logic [13:0]      drain_addr;

    assign drain_addr = {2'b00, drain_reg} - 14'd1;
    assign raddr  = (func == FUNC_DRAIN) ? drain_addr[CW-1:0] : xx;
    assign ram_we = cmd.step && (func_reg == FUNC_PIXEL) && !frame_done;

    gmf3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
        .clk   (clk),
        .we    (ram_we),
        .waddr (xx),
        .wdata (mid_rdata),
        .re    (cmd.accept),
        .raddr (raddr),
        .rdata (up_rdata)
    );

    gmf3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle (
        .clk   (clk),
        .we    (ram_we),
        .waddr (xx),
        .wdata (pixel_reg),
        .re    (cmd.accept),
        .raddr (raddr),
        .rdata (mid_rdata)
    );

    // Window.
    logic [PIX_W-1:0] win_reg [9];
    logic [PIX_W-1:0] win_next [9];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            win_next[i*3]     = win_reg[i*3+1];
            win_next[i*3+1]   = win_reg[i*3+2];
        end
        win_next[2] = up_rdata;
        win_next[5] = mid_rdata;
        win_next[8] = pixel_reg;
    end

    // Item classification, evaluated in the update cycle.
    logic [PIX_W-1:0] pass_pix;
    logic             pass_end;
    kind_t            kind;

    always_comb
    begin
        kind     = RES_NONE;
        pass_pix = win_reg[5];
        pass_end = 1'b0;
        if (func_reg == FUNC_DRAIN)
        begin
            if (frame_done)
            begin
                kind = RES_PASS;
                if (drain_reg != '0)
                begin
                    pass_pix = mid_rdata;
                    pass_end = (drain_reg >= eff_w);
                end
            end
        end
        else if (!frame_done)
        begin
            if (xx == '0)
            begin
                kind = (row_reg >= 12'd2) ? RES_PASS : RES_NONE;
            end
            else if (row_reg == '0)
            begin
                kind = RES_NONE;
            end
            else if (row_reg == 12'd1 || xx == CW'(1))
            begin
                kind = RES_PASS;
            end
            else
            begin
                kind = RES_ROOT;
            end
        end
    end

    // Root engine.
    logic [PROD_W-1:0] prod_reg;
    logic [3:0]        pidx_reg;
    logic [BW-1:0]     bit_reg;
    logic [RW-1:0]     root_reg, cand_reg, cand_w;
    logic [AWP-1:0]    acc_reg, target;
    logic [LW-1:0]     limb_reg;
    logic [2:0]        mcnt_reg;
    logic [RW-1:0]     carry_reg;
    logic [PW-1:0]     limb_prod;
    logic              fits;

    assign cand_w    = root_reg | (RW'(1) << bit_reg);
    assign limb_prod = PW'(acc_reg[{limb_reg, 5'b00000} +: LIMB_W]) * PW'(cand_reg)
                     + PW'(carry_reg);
    assign target    = AWP'(prod_reg) << SHIFT;
    assign fits      = (acc_reg <= target);

    // Staged result and output register.
    logic [OUT_W-1:0] res_value_reg, mean_value_reg;
    logic             res_border_reg, res_end_reg, on_border_reg, frame_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            col_reg    <= '0;
            row_reg    <= '0;
            drain_reg  <= '0;
            for (int i = 0; i < 9; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_WIDTH)
            begin
                width_reg <= cfg_data;
            end
            else
            begin
                height_reg <= cfg_data;
            end
            col_reg   <= '0;
            row_reg   <= '0;
            drain_reg <= '0;
        end
        else if (cmd.step)
        begin
            if (func_reg == FUNC_DRAIN)
            begin
                if (frame_done)
                begin
                    if (drain_reg == '0)
                    begin
                        drain_reg <= 12'd1;
                    end
                    else if (drain_reg >= eff_w)
                    begin
                        col_reg   <= '0;
                        row_reg   <= '0;
                        drain_reg <= '0;
                    end
                    else
                    begin
                        drain_reg <= drain_reg + 12'd1;
                    end
                end
            end
            else if (!frame_done)
            begin
                win_reg <= win_next;
                if (x_inc >= {2'b00, eff_w})
                begin
                    col_reg   <= '0;
                    row_reg   <= row_reg + 12'd1;
                    drain_reg <= '0;
                end
                else
                begin
                    col_reg <= x_inc[CW-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            func_reg  <= func;
            pixel_reg <= pixel;
        end
        if (cmd.step)
        begin
            prod_reg       <= PROD_W'(win_next[0]);
            pidx_reg       <= 4'd1;
            res_value_reg  <= sat16(32'(pass_pix) << FRAC_BITS);
            res_border_reg <= 1'b1;
            res_end_reg    <= pass_end;
        end
        if (cmd.prod_step)
        begin
            prod_reg <= prod_reg * PROD_W'(win_reg[pidx_reg]);
            pidx_reg <= pidx_reg + 4'd1;
            bit_reg  <= BW'(RW - 1);
            root_reg <= '0;
        end
        if (cmd.cand_load)
        begin
            cand_reg  <= cand_w;
            acc_reg   <= AWP'(cand_w);
            limb_reg  <= '0;
            mcnt_reg  <= '0;
            carry_reg <= '0;
        end
        if (cmd.mul_step)
        begin
            acc_reg[{limb_reg, 5'b00000} +: LIMB_W] <= limb_prod[LIMB_W-1:0];
            if (limb_reg == LW'(NL - 1))
            begin
                limb_reg  <= '0;
                carry_reg <= '0;
                mcnt_reg  <= mcnt_reg + 3'd1;
            end
            else
            begin
                limb_reg  <= limb_reg + LW'(1);
                carry_reg <= limb_prod[LIMB_W +: RW];
            end
        end
        if (cmd.cmp_step)
        begin
            if (fits)
            begin
                root_reg <= cand_reg;
            end
            bit_reg        <= bit_reg - BW'(1);
            res_value_reg  <= sat16(32'(fits ? cand_reg : root_reg));
            res_border_reg <= 1'b0;
            res_end_reg    <= 1'b0;
        end
        if (cmd.load_out)
        begin
            mean_value_reg <= res_value_reg;
            on_border_reg  <= res_border_reg;
            frame_end_reg  <= res_end_reg;
        end
    end

    assign status.kind      = kind;
    assign status.prod_last = (pidx_reg == 4'd8);
    assign status.mul_last  = (limb_reg == LW'(NL - 1)) && (mcnt_reg == 3'd7);
    assign status.bit_last  = (bit_reg == '0);

    assign mean_value = mean_value_reg;
    assign on_border  = on_border_reg;
    assign frame_end  = frame_end_reg;

endmodule

// ===== design/geometric_mean_filter_3x3_top.sv =====
// ----------------------------------------------------------------------------
// geometric_mean_filter_3x3_top
// 3x3 geometric mean filter over 8-bit grey pixels streamed in raster order.
// ----------------------------------------------------------------------------
// Pixels enter in raster order, one per transaction, and each interior pixel
// leaves as the truncated ninth root of the product of its 3x3 neighborhood
// in unsigned fixed point with FRAC_BITS fraction bits (8.8 by default);
// border pixels pass through shifted into the same format with on_border
// set. Results trail the input by one row and one pixel, so after the last
// pixel of a frame the user sends image_width+1 drain transactions
// (func = 1) to flush the rest; frame_end marks the final result. The block
// works on one transaction at a time: a pixel that yields no result ends
// after the line store read and window update, a border pass-through then
// goes to the output register, and an interior pixel first forms the window
// product and runs the bitwise root search, which raises each candidate to
// the ninth power on one shared 32-bit limb multiplier; the candidate power
// spans NL 32-bit limbs (5 at the default). A stalled output register holds
// back the next result-producing transaction until it is free. A finished
// result sits in the output register while the next transaction is taken.
// Configuration writes restart the frame counters and must be issued only
// while the block is idle.
// ----------------------------------------------------------------------------
module geometric_mean_filter_3x3_top #(
    parameter int MAX_WIDTH = gmf3_pkg::DEF_MAX_WIDTH,
    parameter int FRAC_BITS = gmf3_pkg::DEF_FRAC_BITS
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // Pixel input channel.
    input  logic                       pix_valid,
    output logic                       pix_stall,
    input  logic                       func,
    input  logic [gmf3_pkg::PIX_W-1:0] pixel,
    // Result output channel.
    output logic                       res_valid,
    input  logic                       res_stall,
    output logic [gmf3_pkg::OUT_W-1:0] mean_value,
    output logic                       on_border,
    output logic                       frame_end,
    // Configuration write port.
    input  logic                       cfg_we,
    input  logic                       cfg_index,
    input  logic [gmf3_pkg::CFG_W-1:0] cfg_data
);
    import gmf3_pkg::*;

    // The controller and datapath talk only through these two bundles.
    cmd_t    cmd;
    status_t status;

    gmf3_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .status    (status),
        .cmd       (cmd)
    );

    gmf3_datapath #(
        .MAX_WIDTH (MAX_WIDTH),
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .func       (func),
        .pixel      (pixel),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cmd        (cmd),
        .status     (status),
        .mean_value (mean_value),
        .on_border  (on_border),
        .frame_end  (frame_end)
    );

endmodule
